[rtl/core/sm64_pkg.sv]
// SplitMix64 byte-stream generator: shared types and constants.
// Used by the front, back and mixer modules and by the top level.
// No dependencies.
`default_nettype none

package sm64_pkg;

    // Request byte count, as carried on the input port and through the queue
    localparam int COUNT_W = 10;
    typedef logic [COUNT_W-1:0] t_count;

    // Largest number of bytes one request can ever produce (64 words of 8 bytes)
    localparam int WORD_BYTES  = 8;
    localparam int WORD_LIMIT  = 64;
    localparam int COUNT_CAP   = WORD_LIMIT * WORD_BYTES;

    // Generator constants
    localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;
    localparam int          SHIFT_A     = 30;
    localparam int          SHIFT_B     = 27;
    localparam int          SHIFT_C     = 31;

    // Head of the request queue, as seen by the back end
    typedef struct packed {
        logic   vld;
        t_count bytes;
    } t_req;

    // Per-word tag that travels alongside the mixer pipeline
    typedef struct packed {
        logic [3:0] nbytes;
        logic       last;
    } t_tag;

endpackage

`default_nettype wire

[rtl/core/splitmix64_byte_stream.sv]
// SplitMix64 byte-stream generator, top level.
// Instantiates sm64_front, sm64_back and sm64_mix; depends on sm64_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one request: a byte count.
//   The count is clamped to the smaller of MAX_REQUEST_BYTES and 512; a
//   request for zero bytes is taken and gives no output.
//   Output channel (o_valid / i_stall) carries one word per 8-byte chunk,
//   bytes packed least significant first, with its valid-byte count and a
//   flag on the final word of the request.
//   A request's first word goes from the queue through the back end's
//   issue register and the mixer stages to the output register. A request
//   of N bytes then streams ceil(N/8) words at one per cycle while i_stall
//   is low; the rate is set by the back end issuing one generator step per
//   cycle into the mixer pipeline. Requests follow each other without gaps.
//   Up to two requests wait in the queue between front and back end.
//   The seed write (i_cfg_we / i_cfg_data) reloads the generator state;
//   write it only while the block is idle.
//   Reset sets the state to zero and empties the queue and the pipeline.
//   While i_stall holds a word, the whole pipeline freezes and the queue
//   fills, after which o_stall rises.
`default_nettype none

module splitmix64_byte_stream
    import sm64_pkg::*;
#(
    parameter int MAX_REQUEST_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [9:0]  i_byte_count_requested,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_random_word,
    output logic [3:0]       o_valid_bytes,
    output logic             o_last_word
);

    localparam int LIMIT_BYTES = (MAX_REQUEST_BYTES < COUNT_CAP)
                               ? MAX_REQUEST_BYTES : COUNT_CAP;

    t_req        req;
    logic        pop;
    logic        en;
    logic        issue_vld;
    logic [63:0] issue_state;
    t_tag        issue_tag;

    sm64_front #(
        .LIMIT_BYTES (LIMIT_BYTES)
    ) u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .i_byte_count_requested (i_byte_count_requested),
        .o_stall                (o_stall),
        .o_req                  (req),
        .i_pop                  (pop)
    );

    sm64_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req),
        .o_pop      (pop),
        .i_en       (en),
        .o_vld      (issue_vld),
        .o_state    (issue_state),
        .o_tag      (issue_tag)
    );

    sm64_mix u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (issue_vld),
        .i_state       (issue_state),
        .i_tag         (issue_tag),
        .o_en          (en),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_random_word (o_random_word),
        .o_valid_bytes (o_valid_bytes),
        .o_last_word   (o_last_word)
    );

endmodule

`default_nettype wire

[rtl/core/sm64_front.sv]
// SplitMix64 front end: accepts requests, clamps the byte count, drops
// empty requests and holds the rest in a two-entry queue.
// Depends on sm64_pkg.
`default_nettype none

module sm64_front
    import sm64_pkg::*;
#(
    parameter int LIMIT_BYTES = 512
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_count i_byte_count_requested,
    output logic        o_stall,
    output t_req        o_req,
    input  wire logic   i_pop
);

    localparam int DEPTH = 2;

    t_count     clamped;
    logic       push;
    t_count     r_mem [DEPTH];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    // Clamp to the request limit and drop zero-byte requests
    always_comb begin
        clamped = (i_byte_count_requested > COUNT_W'(LIMIT_BYTES))
                ? COUNT_W'(LIMIT_BYTES) : i_byte_count_requested;
        push    = i_valid && !o_stall && (clamped != '0);
    end

    assign o_stall   = (r_cnt == 2'(DEPTH));
    assign o_req.vld = (r_cnt != 2'd0);
    assign o_req.bytes = r_mem[r_rptr];

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Store the clamped count
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= clamped;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sm64_back.sv]
// SplitMix64 back end: owns the generator state, splits each queued
// request into 8-byte chunks and issues one state step per cycle while i_en is high.
// Depends on sm64_pkg.
`default_nettype none

module sm64_back
    import sm64_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [63:0] i_cfg_data,
    input  wire t_req        i_req,
    output logic             o_pop,
    input  wire logic        i_en,
    output logic             o_vld,
    output logic [63:0]      o_state,
    output t_tag             o_tag
);

    logic        r_busy;
    t_count      r_rem;
    logic [63:0] r_state;
    logic        active;
    t_count      rem_cur;
    t_count      rem_next;
    logic [3:0]  chunk;
    logic [63:0] state_next;

    // Pick the live byte count and carve off the next chunk
    always_comb begin
        active     = r_busy || i_req.vld;
        rem_cur    = r_busy ? r_rem : i_req.bytes;
        chunk      = (rem_cur >= COUNT_W'(WORD_BYTES)) ? 4'(WORD_BYTES) : rem_cur[3:0];
        rem_next   = rem_cur - COUNT_W'(chunk);
        state_next = r_state + GOLDEN_STEP;
        o_pop      = i_en && !r_busy && i_req.vld;
    end

    // Control and generator state; a seed write reloads the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            o_vld   <= 1'b0;
            r_state <= '0;
        end else begin
            if (i_cfg_we) begin
                r_state <= i_cfg_data;
            end else if (i_en && active) begin
                r_state <= state_next;
            end
            if (i_en) begin
                o_vld <= active;
                if (active) begin
                    r_busy <= (rem_next != '0);
                end
            end
        end
    end

    // Issue register and remaining count
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_state     <= state_next;
            o_tag.nbytes <= chunk;
            o_tag.last  <= (rem_next == '0);
            if (active) begin
                r_rem <= rem_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/sm64_mix.sv]
// SplitMix64 mixer: pipelined xor-shift-multiply rounds built from 32x32
// partial products, one per stage, followed by the byte mask and output register.
// Depends on sm64_pkg.
`default_nettype none

module sm64_mix
    import sm64_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [63:0] i_state,
    input  wire t_tag        i_tag,
    output logic             o_en,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_random_word,
    output logic [3:0]       o_valid_bytes,
    output logic             o_last_word
);

    localparam int STAGES = 6;
    localparam logic [31:0] A_LO = MIX_MUL_A[31:0];
    localparam logic [31:0] A_HI = MIX_MUL_A[63:32];
    localparam logic [31:0] B_LO = MIX_MUL_B[31:0];
    localparam logic [31:0] B_HI = MIX_MUL_B[63:32];

    logic        r_vld [STAGES];
    t_tag        r_tag [STAGES];
    logic [63:0] r1_x, r1_p, r2_x, r2_p, r3_y;
    logic [63:0] r4_x, r4_p, r5_x, r5_p, r6_z;
    logic [63:0] x1, y1, pa1, pb1, wmix, mask;
    logic [31:0] pa2, pa3, pb2, pb3;

    // Advance the whole pipeline unless a finished word is held
    assign o_en = !o_valid || !i_stall;

    // Both rounds' xor-shift and partial products, the final xor-shift and byte mask
    always_comb begin
        x1  = i_state ^ (i_state >> SHIFT_A);
        pa1 = 64'(x1[31:0]) * 64'(A_LO);
        pa2 = r1_x[63:32] * A_LO;
        pa3 = r2_x[31:0] * A_HI;
        y1  = r3_y ^ (r3_y >> SHIFT_B);
        pb1 = 64'(y1[31:0]) * 64'(B_LO);
        pb2 = r4_x[63:32] * B_LO;
        pb3 = r5_x[31:0] * B_HI;
        wmix = r6_z ^ (r6_z >> SHIFT_C);
        for (int k = 0; k < WORD_BYTES; k++) begin
            mask[8*k +: 8] = (4'(k) < r_tag[STAGES-1].nbytes) ? 8'hFF : 8'h00;
        end
    end

    // Valid bits of the stages and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_vld[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (o_en) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < STAGES; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            o_valid <= r_vld[STAGES-1];
        end
    end

    // Datapath and tags
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            r1_x <= x1;
            r1_p <= pa1;
            r2_x <= r1_x;
            r2_p <= r1_p + {pa2, 32'd0};
            r3_y <= r2_p + {pa3, 32'd0};
            r4_x <= y1;
            r4_p <= pb1;
            r5_x <= r4_x;
            r5_p <= r4_p + {pb2, 32'd0};
            r6_z <= r5_p + {pb3, 32'd0};
            o_random_word <= wmix & mask;
            o_valid_bytes <= r_tag[STAGES-1].nbytes;
            o_last_word   <= r_tag[STAGES-1].last;
        end
    end

endmodule

`default_nettype wire
